[rtl/wcc_pkg.sv]
// Shared types, constants and gamma table builder for the WCAG contrast checker.
`timescale 1ns / 1ps

package wcc_pkg;

    // Default fixed-point formats
    localparam int LUMA_FRAC_BITS_DEF  = 16;
    localparam int RATIO_FRAC_BITS_DEF = 8;

    // Ratio has five integer bits; worst case is about 21.0
    localparam int RATIO_INT_W = 5;
    localparam int RATIO_W     = 13;
    localparam int COLOR_W     = 32;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_RATIO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_RATIO  = 2'd1;

    localparam logic [RATIO_W-1:0] NORMAL_RATIO_RST = 13'd1152;
    localparam logic [RATIO_W-1:0] LARGE_RATIO_RST  = 13'd768;

    // Colour masks for the adjusted foreground
    localparam logic [COLOR_W-1:0] ALPHA_MASK = 32'hFF00_0000;
    localparam logic [COLOR_W-1:0] RGB_WHITE  = 32'h00FF_FFFF;

    // Item fields carried alongside the luminance pipeline
    typedef struct packed {
        logic [COLOR_W-1:0] fg_color;
        logic               lg_text;
    } t_item;

    // Item fields carried alongside the divider
    typedef struct packed {
        logic [COLOR_W-1:0] fg_color;
        logic               lg_text;
        logic               bg_dark;
    } t_side;

    // Q0.31 product, truncated
    function automatic logic [63:0] q31_mul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 31;
    endfunction

    function automatic logic [63:0] q31_pow5(input logic [63:0] y);
        logic [63:0] y2;
        logic [63:0] y4;
        y2 = q31_mul(y, y);
        y4 = q31_mul(y2, y2);
        return q31_mul(y4, y);
    endfunction

    // sRGB byte to linear light in Q0.lfb; evaluated at elaboration only
    function automatic logic [31:0] gamma_entry(input int unsigned c, input int unsigned lfb);
        logic [63:0] c64;
        logic [63:0] one;
        logic [63:0] v;
        logic [63:0] w;
        logic [63:0] y;
        logic [63:0] cand;
        logic [63:0] g;
        logic [63:0] r;
        logic [63:0] lmax;
        c64  = 64'(c);
        one  = 64'd1 << 31;
        lmax = (64'd1 << lfb) - 64'd1;
        if (c64 * 64'd100000 <= 64'd1001640) begin
            r = (c64 * 64'd5 * (64'd1 << lfb) + 64'd8236) / 64'd16473;
            return r[31:0];
        end
        v = ((c64 * 64'd1000 + 64'd14025) * one + 64'd134512) / 64'd269025;
        w = q31_mul(v, v);
        y = 64'd0;
        // fifth root of v^2 by bit-wise search, then v^2 * v^0.4 = v^2.4
        for (int bp = 31; bp >= 0; bp--) begin
            cand = y | (64'd1 << bp);
            if (cand <= one) begin
                if (q31_pow5(cand) <= w) begin
                    y = cand;
                end
            end
        end
        g = q31_mul(w, y);
        r = (g + (64'd1 << (30 - lfb))) >> (31 - lfb);
        if (r > lmax) begin
            r = lmax;
        end
        return r[31:0];
    endfunction

endpackage

[rtl/wcc_luma.sv]
// Four-stage relative luminance pipeline for the foreground and background colours.
`timescale 1ns / 1ps

module wcc_luma #(
    parameter int LUMA_FRAC_BITS = wcc_pkg::LUMA_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  wcc_pkg::t_item              i_item,
    input  logic [wcc_pkg::COLOR_W-1:0] i_bg_color,
    output logic                        o_valid,
    output wcc_pkg::t_item              o_item,
    output logic [LUMA_FRAC_BITS-1:0]   o_lum_fg,
    output logic [LUMA_FRAC_BITS-1:0]   o_lum_bg
);

    localparam int LW  = LUMA_FRAC_BITS;
    // weighted sum < 10000 * 2^L
    localparam int SW  = LW + 14;
    // sum / 16, divided next by 625
    localparam int TW  = SW - 4;
    localparam int MW  = LW + 1;
    localparam int QLW = LW + 1;
    localparam int PW  = TW + MW;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << TW) / 64'd625);

    localparam int W_R   = 2126;
    localparam int W_G   = 7152;
    localparam int W_B   = 722;
    localparam int ROUND = 5000;
    localparam int DIV_B = 625;

    // Gamma table, built at elaboration
    logic [LW-1:0] w_gamma [256];
    for (genvar gi = 0; gi < 256; gi++) begin : g_rom
        localparam logic [31:0] ENTRY = wcc_pkg::gamma_entry(gi, LW);
        assign w_gamma[gi] = ENTRY[LW-1:0];
    end

    logic [7:0] w_chan [6];
    always_comb begin
        w_chan[0] = i_item.fg_color[23:16];
        w_chan[1] = i_item.fg_color[15:8];
        w_chan[2] = i_item.fg_color[7:0];
        w_chan[3] = i_bg_color[23:16];
        w_chan[4] = i_bg_color[15:8];
        w_chan[5] = i_bg_color[7:0];
    end

    // Valid bits for the four stages
    logic [3:0] r_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    wcc_pkg::t_item r_item [4];

    // Stage 1: table lookup
    logic [LW-1:0] r1_lin [6];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 6; i++) begin
            r1_lin[i] <= w_gamma[w_chan[i]];
        end
        r_item[0] <= i_item;
    end

    // Stage 2: weighted channel sum plus rounding half
    logic [SW-1:0] n_sum [2];
    logic [SW-1:0] r2_sum [2];
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            n_sum[c] = SW'(r1_lin[3*c])     * SW'(W_R)
                     + SW'(r1_lin[3*c + 1]) * SW'(W_G)
                     + SW'(r1_lin[3*c + 2]) * SW'(W_B)
                     + SW'(ROUND);
        end
    end

    always_ff @(posedge i_clk) begin
        r2_sum    <= n_sum;
        r_item[1] <= r_item[0];
    end

    // Stage 3: estimate of sum / 10000 by reciprocal multiply, low by at most one
    logic [TW-1:0]  w_t [2];
    logic [PW-1:0]  w_prod [2];
    logic [TW-1:0]  r3_t [2];
    logic [QLW-1:0] r3_q [2];
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_t[c]    = r2_sum[c][SW-1:4];
            w_prod[c] = PW'(w_t[c]) * PW'(RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 2; c++) begin
            r3_t[c] <= w_t[c];
            r3_q[c] <= w_prod[c][TW +: QLW];
        end
        r_item[2] <= r_item[1];
    end

    // Stage 4: one correction step and saturation
    logic [TW-1:0]  w_rem [2];
    logic [QLW-1:0] w_q [2];
    logic [LW-1:0]  n_lum [2];
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_rem[c] = r3_t[c] - TW'(r3_q[c]) * TW'(DIV_B);
            w_q[c]   = (w_rem[c] >= TW'(DIV_B)) ? r3_q[c] + QLW'(1) : r3_q[c];
            n_lum[c] = w_q[c][LW] ? {LW{1'b1}} : w_q[c][LW-1:0];
        end
    end

    logic [LW-1:0] r4_lum [2];
    always_ff @(posedge i_clk) begin
        r4_lum    <= n_lum;
        r_item[3] <= r_item[2];
    end

    assign o_valid  = r_valid[3];
    assign o_item   = r_item[3];
    assign o_lum_fg = r4_lum[0];
    assign o_lum_bg = r4_lum[1];

endmodule

[rtl/wcc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, for the contrast ratio.
`timescale 1ns / 1ps

module wcc_div #(
    parameter int LUMA_FRAC_BITS  = wcc_pkg::LUMA_FRAC_BITS_DEF,
    parameter int RATIO_FRAC_BITS = wcc_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    input  logic [LUMA_FRAC_BITS:0]                      i_num,
    input  logic [LUMA_FRAC_BITS:0]                      i_den,
    input  wcc_pkg::t_side                               i_side,
    output logic                                         o_valid,
    output logic [RATIO_FRAC_BITS+wcc_pkg::RATIO_INT_W-1:0] o_quot,
    output wcc_pkg::t_side                               o_side
);

    localparam int LW = LUMA_FRAC_BITS + 1;
    localparam int IW = wcc_pkg::RATIO_INT_W;
    localparam int QW = RATIO_FRAC_BITS + IW;

    // Partial remainder and divisor are not needed past the last stage
    logic [LW-1:0]  r_rem [QW-1];
    logic [LW-1:0]  r_den [QW-1];
    // Low dividend bits shift out at the top as quotient bits shift in
    logic [QW-1:0]  r_qn [QW];
    wcc_pkg::t_side r_side [QW];
    logic [QW-1:0]  r_valid;

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [LW-1:0]  w_rem;
        logic [LW-1:0]  w_den;
        logic [QW-1:0]  w_qn;
        wcc_pkg::t_side w_side;
        logic           w_valid;
        logic [LW:0]    w_sh;
        logic           w_ge;

        if (s == 0) begin : g_first
            // numerator < 32 * divisor, so its top part is already a remainder
            assign w_rem   = i_num >> IW;
            assign w_den   = i_den;
            assign w_qn    = {i_num[IW-1:0], {RATIO_FRAC_BITS{1'b0}}};
            assign w_side  = i_side;
            assign w_valid = i_valid;
        end else begin : g_next
            assign w_rem   = r_rem[s-1];
            assign w_den   = r_den[s-1];
            assign w_qn    = r_qn[s-1];
            assign w_side  = r_side[s-1];
            assign w_valid = r_valid[s-1];
        end

        assign w_sh = {w_rem, w_qn[QW-1]};
        assign w_ge = (w_sh >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_qn[s]   <= {w_qn[QW-2:0], w_ge};
            r_side[s] <= w_side;
        end

        if (s < QW - 1) begin : g_carry
            logic [LW:0] w_diff;
            assign w_diff = w_sh - {1'b0, w_den};
            always_ff @(posedge i_clk) begin
                r_rem[s] <= w_ge ? w_diff[LW-1:0] : w_sh[LW-1:0];
                r_den[s] <= w_den;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quot  = r_qn[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

[rtl/wcag_contrast_checker.sv]
// Top level of the WCAG 2.1 contrast ratio checker.
`timescale 1ns / 1ps

// Checks one foreground/background ARGB32 pair per clock against WCAG 2.1 contrast rules.
//
// Input: an item transfers on a rising edge with i_start high and o_busy low. o_busy is
// only high while i_rst_n is low, so a new pair may be offered on every clock.
// Result: o_valid is high for exactly one cycle with o_contrast_ratio (Q5.8 by default),
// o_meets_threshold and o_adjusted_fg; the receiver cannot hold it off and takes it at
// the edge that ends that cycle.
// Pipeline: between the input transfer and the result lie one gamma lookup stage, three
// luminance stages (weighted sum, reciprocal multiply for /10000, correction), one ordering
// stage, RATIO_FRAC_BITS + 5 divider stages of one quotient bit each, and one output stage.
// Throughput: one item per cycle, results in input order.
// Configuration: register 0 is the normal-text threshold, register 1 the large-text
// threshold, both Q5.8; a transfer on the cfg channel writes one. Write them only while
// no item is in flight. Other indexes are ignored.
// Reset (synchronous, active low) empties the pipeline and restores 4.5 and 3.0.
module wcag_contrast_checker #(
    parameter int LUMA_FRAC_BITS  = wcc_pkg::LUMA_FRAC_BITS_DEF,
    parameter int RATIO_FRAC_BITS = wcc_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [wcc_pkg::COLOR_W-1:0]   i_fg_color,
    input  logic [wcc_pkg::COLOR_W-1:0]   i_bg_color,
    input  logic                          i_large_text,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wcc_pkg::RATIO_W-1:0]   i_cfg_data,
    output logic                          o_valid,
    output logic [wcc_pkg::RATIO_W-1:0]   o_contrast_ratio,
    output logic                          o_meets_threshold,
    output logic [wcc_pkg::COLOR_W-1:0]   o_adjusted_fg
);

    localparam int LW  = LUMA_FRAC_BITS;
    localparam int NW  = LW + 1;
    localparam int QW  = RATIO_FRAC_BITS + wcc_pkg::RATIO_INT_W;
    localparam int RW  = wcc_pkg::RATIO_W;
    // 0.05 in Q0.L, rounded
    localparam logic [NW-1:0] K05 = NW'(((64'd5 << LW) + 64'd50) / 64'd100);

    assign o_busy      = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;

    // Threshold registers
    logic [RW-1:0] r_normal_ratio;
    logic [RW-1:0] r_large_ratio;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_ratio <= wcc_pkg::NORMAL_RATIO_RST;
            r_large_ratio  <= wcc_pkg::LARGE_RATIO_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                wcc_pkg::CFG_NORMAL_RATIO: r_normal_ratio <= i_cfg_data;
                wcc_pkg::CFG_LARGE_RATIO:  r_large_ratio  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Luminance of both colours
    wcc_pkg::t_item w_in_item;
    wcc_pkg::t_item w_luma_item;
    logic           w_luma_valid;
    logic [LW-1:0]  w_lum_fg;
    logic [LW-1:0]  w_lum_bg;

    assign w_in_item.fg_color = i_fg_color;
    assign w_in_item.lg_text  = i_large_text;

    wcc_luma #(
        .LUMA_FRAC_BITS (LUMA_FRAC_BITS)
    ) u_luma (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_start && !o_busy),
        .i_item     (w_in_item),
        .i_bg_color (i_bg_color),
        .o_valid    (w_luma_valid),
        .o_item     (w_luma_item),
        .o_lum_fg   (w_lum_fg),
        .o_lum_bg   (w_lum_bg)
    );

    // Order the luminances and add the 0.05 flare term
    logic           r_ord_valid;
    logic [NW-1:0]  r_num;
    logic [NW-1:0]  r_den;
    wcc_pkg::t_side r_ord_side;
    logic           w_fg_lighter;

    assign w_fg_lighter = (w_lum_fg > w_lum_bg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ord_valid <= 1'b0;
        end else begin
            r_ord_valid <= w_luma_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= NW'(w_fg_lighter ? w_lum_fg : w_lum_bg) + K05;
        r_den <= NW'(w_fg_lighter ? w_lum_bg : w_lum_fg) + K05;
        r_ord_side.fg_color <= w_luma_item.fg_color;
        r_ord_side.lg_text  <= w_luma_item.lg_text;
        r_ord_side.bg_dark  <= ~w_lum_bg[LW-1];
    end

    // Ratio division
    logic           w_div_valid;
    logic [QW-1:0]  w_quot;
    wcc_pkg::t_side w_div_side;

    wcc_div #(
        .LUMA_FRAC_BITS  (LUMA_FRAC_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_ord_valid),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  (r_ord_side),
        .o_valid (w_div_valid),
        .o_quot  (w_quot),
        .o_side  (w_div_side)
    );

    // Saturate the quotient to the output width
    logic [RW-1:0] w_ratio;
    if (QW > RW) begin : g_sat
        assign w_ratio = (|w_quot[QW-1:RW]) ? {RW{1'b1}} : w_quot[RW-1:0];
    end else begin : g_ext
        assign w_ratio = RW'(w_quot);
    end

    // Threshold check and adjusted foreground
    logic [RW-1:0]               w_thr;
    logic [wcc_pkg::COLOR_W-1:0] w_adj;
    assign w_thr = w_div_side.lg_text ? r_large_ratio : r_normal_ratio;

    always_comb begin
        if (w_ratio >= r_normal_ratio) begin
            w_adj = w_div_side.fg_color;
        end else if (w_div_side.bg_dark) begin
            w_adj = (w_div_side.fg_color & wcc_pkg::ALPHA_MASK) | wcc_pkg::RGB_WHITE;
        end else begin
            w_adj = w_div_side.fg_color & wcc_pkg::ALPHA_MASK;
        end
    end

    // Output register
    logic                        r_out_valid;
    logic [RW-1:0]               r_ratio;
    logic                        r_meets;
    logic [wcc_pkg::COLOR_W-1:0] r_adj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ratio <= w_ratio;
        r_meets <= (w_ratio >= w_thr);
        r_adj   <= w_adj;
    end

    assign o_valid           = r_out_valid;
    assign o_contrast_ratio  = r_ratio;
    assign o_meets_threshold = r_meets;
    assign o_adjusted_fg     = r_adj;

endmodule

[rtl/wcc_checker.sv]
// Port-level assertions for the WCAG contrast checker, bound to the top level.
`timescale 1ns / 1ps

module wcc_port_checker #(
    parameter int LATENCY = 19
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          i_busy,
    input logic [wcc_pkg::COLOR_W-1:0]   i_fg_color,
    input logic                          i_large_text,
    input logic                          i_cfg_valid,
    input logic                          i_cfg_ready,
    input logic [wcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [wcc_pkg::RATIO_W-1:0]   i_cfg_data,
    input logic                          i_res_valid,
    input logic [wcc_pkg::RATIO_W-1:0]   i_res_ratio,
    input logic                          i_res_meets,
    input logic [wcc_pkg::COLOR_W-1:0]   i_res_adj
);

    logic w_accept;
    assign w_accept = i_start && !i_busy;

    // Shadow copies of the thresholds, tracked from cfg transfers
    logic [wcc_pkg::RATIO_W-1:0] r_normal;
    logic [wcc_pkg::RATIO_W-1:0] r_large;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal <= wcc_pkg::NORMAL_RATIO_RST;
            r_large  <= wcc_pkg::LARGE_RATIO_RST;
        end else if (i_cfg_valid && i_cfg_ready) begin
            if (i_cfg_index == wcc_pkg::CFG_NORMAL_RATIO) begin
                r_normal <= i_cfg_data;
            end
            if (i_cfg_index == wcc_pkg::CFG_LARGE_RATIO) begin
                r_large <= i_cfg_data;
            end
        end
    end

    // Every accepted pair yields a result after the fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY i_res_valid)
        else $error("accepted pair gave no result");

    // No result without an accepted pair
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> $past(w_accept, LATENCY))
        else $error("result without an accepted pair");

    // Pass flag agrees with the ratio and the threshold the item selected
    a_meets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_meets == ($past(i_large_text, LATENCY)
                                         ? (i_res_ratio >= r_large)
                                         : (i_res_ratio >= r_normal))))
        else $error("pass flag disagrees with ratio");

    // Foreground alpha always survives
    a_alpha_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_adj[31:24] == $past(i_fg_color[31:24], LATENCY)))
        else $error("foreground alpha altered");

    // Sufficient contrast leaves the foreground untouched
    a_fg_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_res_ratio >= r_normal))
        |-> (i_res_adj == $past(i_fg_color, LATENCY)))
        else $error("foreground changed despite sufficient contrast");

endmodule

bind wcag_contrast_checker wcc_port_checker #(
    .LATENCY (RATIO_FRAC_BITS + 11)
) u_wcc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .i_busy       (o_busy),
    .i_fg_color   (i_fg_color),
    .i_large_text (i_large_text),
    .i_cfg_valid  (i_cfg_valid),
    .i_cfg_ready  (o_cfg_ready),
    .i_cfg_index  (i_cfg_index),
    .i_cfg_data   (i_cfg_data),
    .i_res_valid  (o_valid),
    .i_res_ratio  (o_contrast_ratio),
    .i_res_meets  (o_meets_threshold),
    .i_res_adj    (o_adjusted_fg)
);

[dv/wcc_checker.sv]
// Scoreboard for the contrast checker: predicts every result and compares it on arrival.
`timescale 1ns / 1ps

module wcc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [wcc_pkg::COLOR_W-1:0]   i_fg_color,
    input  logic [wcc_pkg::COLOR_W-1:0]   i_bg_color,
    input  logic                          i_large_text,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [wcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wcc_pkg::RATIO_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    input  logic [wcc_pkg::RATIO_W-1:0]   i_contrast_ratio,
    input  logic                          i_meets_threshold,
    input  logic [wcc_pkg::COLOR_W-1:0]   i_adjusted_fg,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int LUMA_FB  = wcc_pkg::LUMA_FRAC_BITS_DEF;
    localparam int RATIO_FB = wcc_pkg::RATIO_FRAC_BITS_DEF;
    localparam int RW       = wcc_pkg::RATIO_W;
    localparam int CW       = wcc_pkg::COLOR_W;

    localparam logic [63:0] Q31_UNITY   = 64'd1 << 31;
    localparam logic [63:0] LUMA_SAT    = (64'd1 << LUMA_FB) - 64'd1;
    localparam logic [63:0] LUMA_HALF   = 64'd1 << (LUMA_FB - 1);
    // 0.05 in the luminance format, rounded
    localparam logic [63:0] LUMA_OFFSET = (64'd5 * (64'd1 << LUMA_FB) + 64'd50) / 64'd100;
    localparam logic [63:0] RATIO_SAT   = (64'd1 << RW) - 64'd1;

    typedef struct packed {
        logic [RW-1:0] ratio;
        logic          meets;
        logic [CW-1:0] adj_fg;
    } t_verdict;

    logic [31:0]   lin_light [256];
    logic [RW-1:0] normal_thr = wcc_pkg::NORMAL_RATIO_RST;
    logic [RW-1:0] large_thr  = wcc_pkg::LARGE_RATIO_RST;
    t_verdict      verdict_q [$];
    int            fails = 0;

    function automatic logic [63:0] q31_prod(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 31;
    endfunction

    // sRGB code to linear light: straight segment below the knee, else v^2.4
    // built as v^2 times the fifth root of v^2
    function automatic logic [31:0] linearise(input int unsigned code);
        logic [63:0] c;
        logic [63:0] base;
        logic [63:0] sq;
        logic [63:0] root;
        logic [63:0] cand;
        logic [63:0] p2;
        logic [63:0] p4;
        logic [63:0] p5;
        logic [63:0] lin;
        c = 64'(code);
        if (c * 64'd100000 <= 64'd1001640) begin
            lin = (c * 64'd5 * (64'd1 << LUMA_FB) + 64'd8236) / 64'd16473;
            return lin[31:0];
        end
        base = ((c * 64'd1000 + 64'd14025) * Q31_UNITY + 64'd134512) / 64'd269025;
        sq   = q31_prod(base, base);
        root = 64'd0;
        for (int k = 31; k >= 0; k--) begin
            cand = root | (64'd1 << k);
            p2   = q31_prod(cand, cand);
            p4   = q31_prod(p2, p2);
            p5   = q31_prod(p4, cand);
            if (cand <= Q31_UNITY && p5 <= sq) begin
                root = cand;
            end
        end
        lin = (q31_prod(sq, root) + (64'd1 << (30 - LUMA_FB))) >> (31 - LUMA_FB);
        if (lin > LUMA_SAT) begin
            lin = LUMA_SAT;
        end
        return lin[31:0];
    endfunction

    initial begin
        for (int c = 0; c < 256; c++) begin
            lin_light[c] = linearise(c);
        end
    end

    // Weighted relative luminance, rounded and saturated
    function automatic logic [63:0] rel_luminance(input logic [CW-1:0] colour);
        logic [63:0] acc;
        acc = 64'd2126 * 64'(lin_light[colour[23:16]])
            + 64'd7152 * 64'(lin_light[colour[15:8]])
            + 64'd722  * 64'(lin_light[colour[7:0]]);
        acc = (acc + 64'd5000) / 64'd10000;
        return (acc > LUMA_SAT) ? LUMA_SAT : acc;
    endfunction

    function automatic t_verdict grade_pair(input logic [CW-1:0] fg,
                                            input logic [CW-1:0] bg,
                                            input logic          lg_sel);
        logic [63:0]   lum_fg;
        logic [63:0]   lum_bg;
        logic [63:0]   lighter;
        logic [63:0]   darker;
        logic [63:0]   quot;
        logic [RW-1:0] thr;
        t_verdict      v;
        lum_fg  = rel_luminance(fg);
        lum_bg  = rel_luminance(bg);
        lighter = (lum_fg > lum_bg) ? lum_fg : lum_bg;
        darker  = (lum_fg > lum_bg) ? lum_bg : lum_fg;
        quot    = ((lighter + LUMA_OFFSET) << RATIO_FB) / (darker + LUMA_OFFSET);
        if (quot > RATIO_SAT) begin
            quot = RATIO_SAT;
        end
        thr     = lg_sel ? large_thr : normal_thr;
        v.ratio = quot[RW-1:0];
        v.meets = (quot >= 64'(thr));
        // Poor contrast: swap to white on a dark background, black otherwise
        if (quot >= 64'(normal_thr)) begin
            v.adj_fg = fg;
        end else if (lum_bg < LUMA_HALF) begin
            v.adj_fg = (fg & wcc_pkg::ALPHA_MASK) | wcc_pkg::RGB_WHITE;
        end else begin
            v.adj_fg = fg & wcc_pkg::ALPHA_MASK;
        end
        return v;
    endfunction

    // Result check first, then register writes, then the new input transfer
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            normal_thr = wcc_pkg::NORMAL_RATIO_RST;
            large_thr  = wcc_pkg::LARGE_RATIO_RST;
            verdict_q.delete();
        end else begin
            if (i_valid) begin
                if (verdict_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result: ratio %0d meets %0b adj %08h",
                             $time, i_contrast_ratio, i_meets_threshold, i_adjusted_fg);
                end else begin
                    want = verdict_q.pop_front();
                    if (i_contrast_ratio !== want.ratio || i_meets_threshold !== want.meets
                        || i_adjusted_fg !== want.adj_fg) begin
                        fails++;
                        $display("%0t: expected %0d/%0b/%08h, got %0d/%0b/%08h",
                                 $time, want.ratio, want.meets, want.adj_fg,
                                 i_contrast_ratio, i_meets_threshold, i_adjusted_fg);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    wcc_pkg::CFG_NORMAL_RATIO: normal_thr = i_cfg_data;
                    wcc_pkg::CFG_LARGE_RATIO:  large_thr  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                verdict_q.push_back(grade_pair(i_fg_color, i_bg_color, i_large_text));
            end
        end
        o_fail_count <= fails;
        o_pending    <= verdict_q.size();
    end

endmodule

[dv/tb_top.sv]
// Top-level testbench for the contrast checker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int RESET_CYCLES    = 11;
    localparam int PIPE_LATENCY    = wcc_pkg::RATIO_FRAC_BITS_DEF + 11;
    localparam int IDLE_LIMIT      = 2000;
    localparam int GAP_MAX         = 13;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int CW              = wcc_pkg::COLOR_W;
    localparam int RW              = wcc_pkg::RATIO_W;
    localparam int IW              = wcc_pkg::CFG_IDX_W;

    // Indexes outside the register map; writes to them must be ignored
    localparam logic [IW-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [IW-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [RW-1:0] RATIO_ZERO = '0;
    localparam logic [RW-1:0] RATIO_ONE  = 13'd256;
    localparam logic [RW-1:0] RATIO_TOP  = 13'd5376;
    localparam logic [RW-1:0] RATIO_FULL = '1;

    // Channel codes around the gamma knee, mid scale, half luminance and the ends
    localparam logic [7:0] KNEE_LEVELS [10] = '{8'h00, 8'h01, 8'h0A, 8'h0B, 8'h7F,
                                               8'h80, 8'hBB, 8'hBC, 8'hFE, 8'hFF};

    logic          i_clk        = 1'b0;
    logic          i_rst_n      = 1'b0;
    logic          i_start      = 1'b0;
    logic [CW-1:0] i_fg_color   = '0;
    logic [CW-1:0] i_bg_color   = '0;
    logic          i_large_text = 1'b0;
    logic          i_cfg_valid  = 1'b0;
    logic [IW-1:0] i_cfg_index  = '0;
    logic [RW-1:0] i_cfg_data   = '0;
    logic          o_busy;
    logic          o_cfg_ready;
    logic          o_valid;
    logic [RW-1:0] o_contrast_ratio;
    logic          o_meets_threshold;
    logic [CW-1:0] o_adjusted_fg;
    int            fail_count;
    int            pending;
    int            burst_left = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    wcag_contrast_checker dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_fg_color        (i_fg_color),
        .i_bg_color        (i_bg_color),
        .i_large_text      (i_large_text),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_contrast_ratio  (o_contrast_ratio),
        .o_meets_threshold (o_meets_threshold),
        .o_adjusted_fg     (o_adjusted_fg)
    );

    wcc_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .i_busy            (o_busy),
        .i_fg_color        (i_fg_color),
        .i_bg_color        (i_bg_color),
        .i_large_text      (i_large_text),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (o_valid),
        .i_contrast_ratio  (o_contrast_ratio),
        .i_meets_threshold (o_meets_threshold),
        .i_adjusted_fg     (o_adjusted_fg),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // Gap before the next pair: mostly random, sometimes a back-to-back burst
    function automatic int draw_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, GAP_MAX);
    endfunction

    function automatic logic [7:0] knee_level();
        return KNEE_LEVELS[$urandom_range(0, 9)];
    endfunction

    // Random colour pair from one of several mixes that stress different paths
    task automatic draw_pair(output logic [CW-1:0] fg, output logic [CW-1:0] bg,
                             output logic lg);
        logic [7:0] g;
        logic [7:0] h;
        lg = 1'($urandom_range(0, 1));
        fg = $urandom;
        bg = $urandom;
        case ($urandom_range(0, 5))
            // greys on greys
            1: begin
                g = 8'($urandom);
                h = 8'($urandom);
                fg[23:0] = {g, g, g};
                bg[23:0] = {h, h, h};
            end
            // nearly the same colour, ratio close to one
            2: bg[23:0] = fg[23:0] ^ (24'($urandom) & 24'h07_0707);
            3: begin
                fg[23:0] = {knee_level(), knee_level(), knee_level()};
                bg[23:0] = {knee_level(), knee_level(), knee_level()};
            end
            4: bg[23:0] = $urandom_range(0, 1) ? wcc_pkg::RGB_WHITE[23:0] : 24'h00_0000;
            // greys near the 3.0 and 4.5 thresholds against white or black
            5: begin
                g = 8'($urandom_range(8'h68, 8'hA0));
                fg[23:0] = {g, g, g};
                bg[23:0] = $urandom_range(0, 1) ? wcc_pkg::RGB_WHITE[23:0] : 24'h00_0000;
            end
            default: ;
        endcase
    endtask

    // Offer one pair; start stays high into the next item when there is no gap
    task automatic send_pair(input logic [CW-1:0] fg, input logic [CW-1:0] bg,
                             input logic lg);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) begin
                i_fg_color   <= $urandom;
                i_bg_color   <= $urandom;
                i_large_text <= 1'($urandom_range(0, 1));
                @(posedge i_clk);
            end
        end
        i_start      <= 1'b1;
        i_fg_color   <= fg;
        i_bg_color   <= bg;
        i_large_text <= lg;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Hold off until every predicted result has been seen
    task automatic drain_results();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Both thresholds, then a spare index that must not alias onto either
    task automatic program_thresholds(input logic [RW-1:0] normal_val,
                                      input logic [RW-1:0] large_val);
        logic [IW-1:0] idx [3];
        logic [RW-1:0] dat [3];
        idx[0] = wcc_pkg::CFG_NORMAL_RATIO;
        dat[0] = normal_val;
        idx[1] = wcc_pkg::CFG_LARGE_RATIO;
        dat[1] = large_val;
        idx[2] = $urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B;
        dat[2] = RW'($urandom);
        for (int n = 0; n < 3; n++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[n];
            i_cfg_data  <= dat[n];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [CW-1:0] fg;
        logic [CW-1:0] bg;
        logic          lg;
        logic [RW-1:0] normal_val;
        logic [RW-1:0] large_val;
        int            pause_at;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pairs at the reset thresholds
        send_pair(32'hFF00_0000, 32'hFFFF_FFFF, 1'b0);  // black on white, widest ratio
        send_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);  // white on black
        send_pair(32'h0077_7777, 32'hFF77_7777, 1'b0);  // equal luminance
        send_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_pair(32'h800A_0A0A, 32'h000B_0B0B, 1'b0);  // either side of the gamma knee
        send_pair(32'h12FF_0000, 32'h0000_FF00, 1'b0);
        send_pair(32'h3400_00FF, 32'h0000_0000, 1'b1);
        send_pair(32'h5640_4040, 32'h0020_2020, 1'b0);  // poor contrast, dark background
        send_pair(32'h78C0_C0C0, 32'hFFE0_E0E0, 1'b0);  // poor contrast, light background
        send_pair(32'hAB99_9999, 32'h00BB_BBBB, 1'b0);  // background just under half
        send_pair(32'hCD99_9999, 32'h00BC_BCBC, 1'b1);  // background just over half
        send_pair(32'hFF76_7676, 32'hFFFF_FFFF, 1'b0);  // just above 4.5
        send_pair(32'hFF77_7777, 32'hFFFF_FFFF, 1'b0);  // just below 4.5
        send_pair(32'hFF94_9494, 32'hFFFF_FFFF, 1'b1);  // just above 3.0
        send_pair(32'hFF95_9595, 32'hFFFF_FFFF, 1'b1);  // just below 3.0
        send_pair(32'h0001_0101, 32'h00FE_FEFE, 1'b0);
        send_pair(32'hFF0A_0000, 32'h0000_00FF, 1'b1);
        send_pair(32'h5AA5_A5A5, 32'hA55A_5A5A, 1'b0);
        send_pair(32'hA55A_5A5A, 32'h5AA5_A5A5, 1'b1);
        drain_results();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    normal_val = wcc_pkg::NORMAL_RATIO_RST;
                    large_val  = wcc_pkg::LARGE_RATIO_RST;
                end
                1: begin normal_val = RATIO_ONE;        large_val = RATIO_TOP;       end
                2: begin normal_val = RATIO_TOP;        large_val = RATIO_ONE;       end
                3: begin normal_val = RATIO_ZERO;       large_val = RATIO_FULL;      end
                4: begin normal_val = RATIO_FULL;       large_val = RATIO_ZERO;      end
                7: begin
                    normal_val = RW'($urandom);
                    large_val  = RW'($urandom);
                end
                default: begin
                    normal_val = RW'($urandom_range(RATIO_ONE, RATIO_TOP));
                    large_val  = RW'($urandom_range(RATIO_ONE, RATIO_TOP));
                end
            endcase
            program_thresholds(normal_val, large_val);
            pause_at = $urandom_range(20, ITEMS_PER_PHASE - 20);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                draw_pair(fg, bg, lg);
                send_pair(fg, bg, lg);
                if (n == pause_at) begin
                    drain_results();
                end
            end
            drain_results();
        end

        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Ends the run if no transfer of any kind happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[wcag_contrast_checker.f]
rtl/wcc_pkg.sv
rtl/wcc_luma.sv
rtl/wcc_div.sv
rtl/wcag_contrast_checker.sv
rtl/wcc_checker.sv
dv/wcc_checker.sv
dv/tb_top.sv
